// ----- rtl/swscm_pkg.sv -----
// Shared types and constants of the sigma-clipped moving average block.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package swscm_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_SAMPLE_BITS  = 10;

    // Fixed field widths.
    localparam int ABSORB_BITS  = 8;
    localparam int WLEN_BITS    = 5;
    localparam int MEAN_BITS    = 10;
    localparam int COUNT_BITS   = 5;
    localparam int DIVISOR_BITS = 8;
    localparam int STEP_BITS    = 6;

    // Configuration register indexes.
    localparam logic CFG_ABSORB = 1'b0;
    localparam logic CFG_WLEN   = 1'b1;

    // Command to the shared divide / square root unit.
    typedef struct packed {
        logic                 start;
        logic                 is_sqrt;
        logic [STEP_BITS-1:0] steps;
    } swscm_cmd_t;

    // Status of the shared unit.
    typedef struct packed {
        logic busy;
        logic done;
    } swscm_stat_t;

    // Control of the window store.
    typedef struct packed {
        logic push;
        logic rotate;
    } swscm_win_ctl_t;

endpackage

// ----- rtl/swscm_divsqrt.sv -----
// Shared iterative unit: restoring divide (one quotient bit per cycle) and
// digit-by-digit square root (two radicand bits per cycle). Uses swscm_pkg.
`timescale 1ns / 1ps

module swscm_divsqrt #(
    parameter int OPER_BITS = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swscm_pkg::swscm_cmd_t              cmd,
    input  logic [OPER_BITS-1:0]               dividend,
    input  logic [swscm_pkg::DIVISOR_BITS-1:0] divisor,
    output swscm_pkg::swscm_stat_t             stat,
    output logic [OPER_BITS-1:0]               quotient
);

    localparam int RW = OPER_BITS / 2 + 2;

    logic [OPER_BITS-1:0]               num_reg;
    logic [OPER_BITS-1:0]               q_reg;
    logic [RW-1:0]                      rem_reg;
    logic [swscm_pkg::STEP_BITS-1:0]    cnt_reg;
    logic [swscm_pkg::DIVISOR_BITS-1:0] dvs_reg;
    logic                               sqrt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic [RW-1:0]                      shifted;
    logic [RW-1:0]                      trial;
    logic                               ge;
    logic [swscm_pkg::STEP_BITS-1:0]    align;

    always_comb
    begin
        if (sqrt_reg)
        begin
            shifted = {rem_reg[RW-3:0], num_reg[OPER_BITS-1 -: 2]};
            trial   = {q_reg[RW-3:0], 2'b01};
        end
        else
        begin
            shifted = {rem_reg[RW-2:0], num_reg[OPER_BITS-1]};
            trial   = RW'(dvs_reg);
        end
    end

    assign ge = (shifted >= trial);

    // The operand is left-aligned so that only the requested steps run.
    assign align = swscm_pkg::STEP_BITS'(OPER_BITS)
                   - (cmd.is_sqrt ? {cmd.steps[swscm_pkg::STEP_BITS-2:0], 1'b0} : cmd.steps);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= cmd.is_sqrt;
                cnt_reg  <= cmd.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == swscm_pkg::STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && !busy_reg)
        begin
            num_reg <= dividend << align;
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - trial) : shifted;
            q_reg   <= {q_reg[OPER_BITS-2:0], ge};
            num_reg <= sqrt_reg ? (num_reg << 2) : (num_reg << 1);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// ----- rtl/swscm_window.sv -----
// Window store: shift register of group averages with push and rotate over
// the entries in use, so a walk always reads entry zero. Uses swscm_pkg.
`timescale 1ns / 1ps

module swscm_window #(
    parameter int WINDOW_DEPTH = swscm_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = swscm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swscm_pkg::swscm_win_ctl_t          ctl,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0]  len,
    input  logic [SAMPLE_BITS-1:0]             push_data,
    output logic [SAMPLE_BITS-1:0]             head
);

    localparam int LW = $clog2(WINDOW_DEPTH + 1);

    logic [SAMPLE_BITS-1:0] entry_reg [WINDOW_DEPTH];

    // Entries at or beyond len keep their values on both push and rotate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                if (LW'(i) < len)
                begin
                    if (ctl.push)
                    begin
                        entry_reg[i] <= (i == 0) ? push_data
                                        : entry_reg[(i + WINDOW_DEPTH - 1) % WINDOW_DEPTH];
                    end
                    else if (ctl.rotate)
                    begin
                        entry_reg[i] <= (LW'(i) == len - 1'b1) ? entry_reg[0]
                                        : entry_reg[(i + 1) % WINDOW_DEPTH];
                    end
                end
            end
        end
    end

    assign head = entry_reg[0];

endmodule

// ----- rtl/sliding_window_sigma_clipped_mean.sv -----
// Sigma-clipped moving average. An item that does not close a group is added to it.
// A closing item runs three or four divides and one square root in the shared unit
// (one quotient bit, or two radicand bits, per cycle) plus three walks over the entries
// of the window in use. The result then waits in an output register while the next
// item is taken.
// Reset is asynchronous: window entries and the group clear, absorb_count is 1, window_length 16.
`timescale 1ns / 1ps

module sliding_window_sigma_clipped_mean #(
    parameter int WINDOW_DEPTH = swscm_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = swscm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [swscm_pkg::ABSORB_BITS-1:0] cfg_data,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [swscm_pkg::MEAN_BITS-1:0]   corrected_mean,
    output logic [swscm_pkg::MEAN_BITS-1:0]   raw_mean,
    output logic [swscm_pkg::MEAN_BITS-1:0]   deviation,
    output logic [swscm_pkg::COUNT_BITS-1:0]  kept_count,
    output logic                              clipped_used
);

    localparam int LW         = $clog2(WINDOW_DEPTH + 1);
    localparam int DW         = 2 * SAMPLE_BITS + 2 * (($clog2(WINDOW_DEPTH) + 1) / 2);
    localparam int DVB        = DW / 2;
    localparam int SUM_BITS   = SAMPLE_BITS + swscm_pkg::ABSORB_BITS;
    localparam int SUM_STEPS  = SUM_BITS;
    localparam int MEAN_STEPS = SAMPLE_BITS + LW;
    localparam int VAR_STEPS  = DW;
    localparam int ROOT_STEPS = DW / 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GDIV   = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_MDIV   = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_SQLAST = 4'd5;
    localparam logic [3:0] S_VDIV   = 4'd6;
    localparam logic [3:0] S_ROOT   = 4'd7;
    localparam logic [3:0] S_KEEP   = 4'd8;
    localparam logic [3:0] S_KDIV   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]                        state_reg, state_next;
    logic [swscm_pkg::ABSORB_BITS-1:0] absorb_reg;
    logic [swscm_pkg::WLEN_BITS-1:0]   wlen_reg;
    logic [SUM_BITS-1:0]               gsum_reg, gsum_next;
    logic [swscm_pkg::ABSORB_BITS-1:0] gcnt_reg, gcnt_next;
    logic [DW-1:0]                     acc_reg, acc_next;
    logic [LW-1:0]                     idx_reg, idx_next;
    logic [LW-1:0]                     kept_reg, kept_next;
    logic [SAMPLE_BITS-1:0]            raw_reg, raw_next;
    logic [DVB-1:0]                    dev_reg, dev_next;
    logic [SAMPLE_BITS-1:0]            corr_reg, corr_next;
    logic                              used_reg, used_next;
    logic [2*SAMPLE_BITS-1:0]          prod_reg, prod_next;
    logic                              pv_reg, pv_next;
    logic                              valid_reg;
    logic                              load;

    logic [swscm_pkg::MEAN_BITS-1:0]   out_corr_reg;
    logic [swscm_pkg::MEAN_BITS-1:0]   out_raw_reg;
    logic [swscm_pkg::MEAN_BITS-1:0]   out_dev_reg;
    logic [swscm_pkg::COUNT_BITS-1:0]  out_kept_reg;
    logic                              out_used_reg;

    swscm_pkg::swscm_cmd_t             dsu_cmd;
    swscm_pkg::swscm_stat_t            dsu_stat;
    logic [DW-1:0]                     dsu_dividend;
    logic [swscm_pkg::DIVISOR_BITS-1:0] dsu_divisor;
    logic [DW-1:0]                     dsu_q;

    swscm_pkg::swscm_win_ctl_t         win_ctl;
    logic [SAMPLE_BITS-1:0]            head;

    logic [LW-1:0]                     len;
    logic [LW-1:0]                     len_m1;
    logic [swscm_pkg::ABSORB_BITS-1:0] absorb_eff;
    logic [SUM_BITS-1:0]               gsum_add;
    logic [swscm_pkg::ABSORB_BITS-1:0] gcnt_inc;
    logic [DW-1:0]                     acc_sum;
    logic signed [SAMPLE_BITS:0]       diff;
    logic signed [2*SAMPLE_BITS+1:0]   diff_sq;
    logic                              in_band;
    logic [LW-1:0]                     kept_after;
    logic [DW-1:0]                     acc_after;

    // Window length below two acts as two, above the depth as the depth.
    always_comb
    begin
        if (wlen_reg < swscm_pkg::WLEN_BITS'(2))
        begin
            len = LW'(2);
        end
        else if (32'(wlen_reg) > WINDOW_DEPTH)
        begin
            len = LW'(WINDOW_DEPTH);
        end
        else
        begin
            len = LW'(wlen_reg);
        end
    end

    assign len_m1     = len - 1'b1;
    assign absorb_eff = (absorb_reg == '0) ? swscm_pkg::ABSORB_BITS'(1) : absorb_reg;
    assign gsum_add   = gsum_reg + SUM_BITS'(sample);
    assign gcnt_inc   = gcnt_reg + 1'b1;
    assign acc_sum    = acc_reg + DW'(head);
    assign diff       = $signed({1'b0, head}) - $signed({1'b0, raw_reg});
    assign diff_sq    = diff * diff;

    // Strictly inside (raw - dev, raw + dev), written without signed values.
    assign in_band    = ((DVB+1)'(head) + (DVB+1)'(dev_reg) > (DVB+1)'(raw_reg))
                        && ((DVB+1)'(head) < (DVB+1)'(raw_reg) + (DVB+1)'(dev_reg));
    assign kept_after = in_band ? kept_reg + 1'b1 : kept_reg;
    assign acc_after  = in_band ? acc_sum : acc_reg;

    always_comb
    begin
        state_next   = state_reg;
        gsum_next    = gsum_reg;
        gcnt_next    = gcnt_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        kept_next    = kept_reg;
        raw_next     = raw_reg;
        dev_next     = dev_reg;
        corr_next    = corr_reg;
        used_next    = used_reg;
        prod_next    = prod_reg;
        pv_next      = pv_reg;
        load         = 1'b0;
        dsu_cmd      = '0;
        dsu_dividend = '0;
        dsu_divisor  = '0;
        win_ctl      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    if (gcnt_inc < absorb_eff)
                    begin
                        gsum_next = gsum_add;
                        gcnt_next = gcnt_inc;
                    end
                    else
                    begin
                        gsum_next     = '0;
                        gcnt_next     = '0;
                        dsu_cmd.start = 1'b1;
                        dsu_cmd.steps = swscm_pkg::STEP_BITS'(SUM_STEPS);
                        dsu_dividend  = DW'(gsum_add);
                        dsu_divisor   = absorb_eff;
                        state_next    = S_GDIV;
                    end
                end
            end
            S_GDIV:
            begin
                if (dsu_stat.done)
                begin
                    win_ctl.push = 1'b1;
                    acc_next     = '0;
                    idx_next     = '0;
                    state_next   = S_SUM;
                end
            end
            S_SUM:
            begin
                win_ctl.rotate = 1'b1;
                acc_next       = acc_sum;
                idx_next       = idx_reg + 1'b1;
                if (idx_reg == len_m1)
                begin
                    dsu_cmd.start = 1'b1;
                    dsu_cmd.steps = swscm_pkg::STEP_BITS'(MEAN_STEPS);
                    dsu_dividend  = acc_sum;
                    dsu_divisor   = swscm_pkg::DIVISOR_BITS'(len);
                    state_next    = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (dsu_stat.done)
                begin
                    raw_next   = dsu_q[SAMPLE_BITS-1:0];
                    acc_next   = '0;
                    idx_next   = '0;
                    pv_next    = 1'b0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                // The square is registered and added in the next cycle.
                win_ctl.rotate = 1'b1;
                prod_next      = diff_sq[2*SAMPLE_BITS-1:0];
                pv_next        = 1'b1;
                acc_next       = pv_reg ? acc_reg + DW'(prod_reg) : acc_reg;
                idx_next       = idx_reg + 1'b1;
                if (idx_reg == len_m1)
                begin
                    state_next = S_SQLAST;
                end
            end
            S_SQLAST:
            begin
                dsu_cmd.start = 1'b1;
                dsu_cmd.steps = swscm_pkg::STEP_BITS'(VAR_STEPS);
                dsu_dividend  = acc_reg + DW'(prod_reg);
                dsu_divisor   = swscm_pkg::DIVISOR_BITS'(len_m1);
                state_next    = S_VDIV;
            end
            S_VDIV:
            begin
                if (dsu_stat.done)
                begin
                    dsu_cmd.start   = 1'b1;
                    dsu_cmd.is_sqrt = 1'b1;
                    dsu_cmd.steps   = swscm_pkg::STEP_BITS'(ROOT_STEPS);
                    dsu_dividend    = dsu_q;
                    state_next      = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (dsu_stat.done)
                begin
                    dev_next   = dsu_q[DVB-1:0];
                    acc_next   = '0;
                    kept_next  = '0;
                    idx_next   = '0;
                    state_next = S_KEEP;
                end
            end
            S_KEEP:
            begin
                win_ctl.rotate = 1'b1;
                acc_next       = acc_after;
                kept_next      = kept_after;
                idx_next       = idx_reg + 1'b1;
                if (idx_reg == len_m1)
                begin
                    if (dev_reg != '0 && kept_after != '0)
                    begin
                        dsu_cmd.start = 1'b1;
                        dsu_cmd.steps = swscm_pkg::STEP_BITS'(MEAN_STEPS);
                        dsu_dividend  = acc_after;
                        dsu_divisor   = swscm_pkg::DIVISOR_BITS'(kept_after);
                        state_next    = S_KDIV;
                    end
                    else
                    begin
                        corr_next  = raw_reg;
                        used_next  = 1'b0;
                        state_next = S_OUT;
                    end
                end
            end
            S_KDIV:
            begin
                if (dsu_stat.done)
                begin
                    corr_next  = dsu_q[SAMPLE_BITS-1:0];
                    used_next  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!valid_reg || !result_stall)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            absorb_reg <= swscm_pkg::ABSORB_BITS'(1);
            wlen_reg   <= swscm_pkg::WLEN_BITS'(16);
            gsum_reg   <= '0;
            gcnt_reg   <= '0;
            idx_reg    <= '0;
            pv_reg     <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gsum_reg  <= gsum_next;
            gcnt_reg  <= gcnt_next;
            idx_reg   <= idx_next;
            pv_reg    <= pv_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    swscm_pkg::CFG_ABSORB: absorb_reg <= cfg_data;
                    swscm_pkg::CFG_WLEN:   wlen_reg   <= cfg_data[swscm_pkg::WLEN_BITS-1:0];
                    default:               absorb_reg <= absorb_reg;
                endcase
            end
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        kept_reg <= kept_next;
        raw_reg  <= raw_next;
        dev_reg  <= dev_next;
        corr_reg <= corr_next;
        used_reg <= used_next;
        prod_reg <= prod_next;
        if (load)
        begin
            out_corr_reg <= swscm_pkg::MEAN_BITS'(corr_reg);
            out_raw_reg  <= swscm_pkg::MEAN_BITS'(raw_reg);
            out_dev_reg  <= swscm_pkg::MEAN_BITS'(dev_reg);
            out_kept_reg <= swscm_pkg::COUNT_BITS'(kept_reg);
            out_used_reg <= used_reg;
        end
    end

    swscm_divsqrt #(
        .OPER_BITS(DW)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dsu_cmd),
        .dividend (dsu_dividend),
        .divisor  (dsu_divisor),
        .stat     (dsu_stat),
        .quotient (dsu_q)
    );

    swscm_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .len       (len),
        .push_data (dsu_q[SAMPLE_BITS-1:0]),
        .head      (head)
    );

    assign cfg_ready      = 1'b1;
    assign sample_stall   = (state_reg != S_IDLE);
    assign result_valid   = valid_reg;
    assign corrected_mean = out_corr_reg;
    assign raw_mean       = out_raw_reg;
    assign deviation      = out_dev_reg;
    assign kept_count     = out_kept_reg;
    assign clipped_used   = out_used_reg;

    // The shared unit is never restarted while it is still iterating.
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dsu_cmd.start |-> !dsu_stat.busy)
        else $error("shared unit started while busy");

    // A finished operation is only reported while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dsu_stat.done |-> (state_reg == S_GDIV || state_reg == S_MDIV
                           || state_reg == S_VDIV || state_reg == S_ROOT
                           || state_reg == S_KDIV))
        else $error("shared unit finished outside a wait state");

    // The kept count never runs past the entries already visited.
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KEEP |-> kept_reg <= idx_reg)
        else $error("kept count exceeds walked entries");

    // An item is only taken when no closing item is still at work.
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> ($past(state_reg) == S_IDLE))
        else $error("item taken while busy");

endmodule
